FILE: src/tpec_pkg.sv
// ----------------------------------------------------------------------------
// tpec_pkg
// Shared widths, note thresholds and effect codes for the pattern event
// converter.
// ----------------------------------------------------------------------------
package tpec_pkg;

  localparam int PERIOD_W = 12;
  localparam int NOTE_W   = 6;
  localparam int INS_W    = 7;
  localparam int VOL_W    = 7;
  localparam int FX_W     = 4;
  localparam int PARAM_W  = 8;
  localparam int EVENT_W  = NOTE_W + INS_W + VOL_W + FX_W + PARAM_W;
  localparam int NUM_THR  = 12;

  typedef logic [PERIOD_W-1:0] period_t;
  typedef logic [FX_W-1:0]     fx_t;
  typedef logic [PARAM_W-1:0]  param_t;

  // Upper period bound of each semitone once the period is normalized so
  // that bit 11 is set: floor(13696 * 2^(-(43+2i)/24)).
  localparam period_t NOTE_THR [NUM_THR] = '{
    12'd3955, 12'd3733, 12'd3524, 12'd3326, 12'd3139, 12'd2963,
    12'd2797, 12'd2640, 12'd2492, 12'd2352, 12'd2220, 12'd2095
  };
  // note = 12*shift + 21 + count - 36
  localparam logic [7:0] NOTE_BIAS = 8'd15;

  localparam logic [NOTE_W-1:0]  NOTE_EMPTY  = '1;
  localparam logic [VOL_W-1:0]   VOL_EMPTY   = '1;
  localparam fx_t                FX_EMPTY    = '1;
  localparam param_t             PARAM_EMPTY = '1;

  // Source effect numbers
  localparam fx_t SRC_ARP       = 4'h0;
  localparam fx_t SRC_PORTA_UP  = 4'h1;
  localparam fx_t SRC_PORTA_DN  = 4'h2;
  localparam fx_t SRC_TONE      = 4'h3;
  localparam fx_t SRC_VIB       = 4'h4;
  localparam fx_t SRC_TONE_VS   = 4'h5;
  localparam fx_t SRC_VIB_VS    = 4'h6;
  localparam fx_t SRC_TREM      = 4'h7;
  localparam fx_t SRC_PAN       = 4'h8;
  localparam fx_t SRC_OFFSET    = 4'h9;
  localparam fx_t SRC_VSLIDE    = 4'hA;
  localparam fx_t SRC_JUMP      = 4'hB;
  localparam fx_t SRC_SET_VOL   = 4'hC;
  localparam fx_t SRC_BREAK     = 4'hD;
  localparam fx_t SRC_EXT       = 4'hE;
  localparam fx_t SRC_SPEED     = 4'hF;

  // Source extended sub-commands
  localparam fx_t SX_FILTER     = 4'h0;
  localparam fx_t SX_FINE_UP    = 4'h1;
  localparam fx_t SX_FINE_DN    = 4'h2;
  localparam fx_t SX_GLISS      = 4'h3;
  localparam fx_t SX_VIB_WAVE   = 4'h4;
  localparam fx_t SX_FINETUNE   = 4'h5;
  localparam fx_t SX_LOOP       = 4'h6;
  localparam fx_t SX_TREM_WAVE  = 4'h7;
  localparam fx_t SX_PAN        = 4'h8;
  localparam fx_t SX_RETRIG     = 4'h9;
  localparam fx_t SX_FVOL_UP    = 4'hA;
  localparam fx_t SX_FVOL_DN    = 4'hB;
  localparam fx_t SX_CUT        = 4'hC;
  localparam fx_t SX_DELAY      = 4'hD;
  localparam fx_t SX_PDELAY     = 4'hE;
  localparam fx_t SX_INV_LOOP   = 4'hF;

  // Target effect numbers
  localparam fx_t DST_SPEED     = 4'd0;
  localparam fx_t DST_VIB       = 4'd1;
  localparam fx_t DST_BREAK     = 4'd2;
  localparam fx_t DST_PORTA_DN  = 4'd3;
  localparam fx_t DST_PORTA_UP  = 4'd4;
  localparam fx_t DST_ARP       = 4'd6;
  localparam fx_t DST_PAN       = 4'd7;
  localparam fx_t DST_MISC      = 4'd8;
  localparam fx_t DST_JUMP      = 4'd9;
  localparam fx_t DST_TREM      = 4'd10;
  localparam fx_t DST_VSLIDE    = 4'd11;
  localparam fx_t DST_EXT       = 4'd12;
  localparam fx_t DST_TONE      = 4'd13;
  localparam fx_t DST_OFFSET    = 4'd14;

  // Target misc-group sub-commands (upper parameter nibble)
  localparam fx_t MSC_VIBVS_UP  = 4'd0;
  localparam fx_t MSC_VIBVS_DN  = 4'd1;
  localparam fx_t MSC_TONVS_UP  = 4'd2;
  localparam fx_t MSC_TONVS_DN  = 4'd3;
  localparam fx_t MSC_INV_LOOP  = 4'd4;
  localparam fx_t MSC_FILTER    = 4'd5;

  // Target extended sub-commands (upper parameter nibble)
  localparam fx_t EXT_FINE_UP   = 4'd0;
  localparam fx_t EXT_FINE_DN   = 4'd1;
  localparam fx_t EXT_FVOL_UP   = 4'd2;
  localparam fx_t EXT_FVOL_DN   = 4'd3;
  localparam fx_t EXT_VIB_WAVE  = 4'd4;
  localparam fx_t EXT_TREM_WAVE = 4'd5;
  localparam fx_t EXT_RETRIG    = 4'd6;
  localparam fx_t EXT_CUT       = 4'd7;
  localparam fx_t EXT_DELAY     = 4'd8;
  localparam fx_t EXT_LOOP      = 4'd11;
  localparam fx_t EXT_PDELAY    = 4'd12;

  // Two BCD digits of a value 0..64; tens by multiply-shift (exact below 69).
  function automatic param_t to_bcd(input logic [6:0] v);
    logic [10:0] prod;
    logic [3:0]  tens;
    logic [6:0]  t10;
    logic [6:0]  ones;
    prod = {4'b0, v} * 11'd13;
    tens = prod[10:7];
    t10  = {3'b0, tens} * 7'd10;
    ones = v - t10;
    return {tens, ones[3:0]};
  endfunction

endpackage

FILE: src/tracker_pattern_event_converter_core.sv
// ----------------------------------------------------------------------------
// tracker_pattern_event_converter_core
// Repacks one four-byte tracker pattern event into a 32-bit event word.
// ----------------------------------------------------------------------------
//
//  channel  | ports                                  | transfer
//  ---------+----------------------------------------+---------------------------
//  input    | start, busy, in_event_byte0..3         | start high, busy low
//  result   | out_strobe, out_packed_event           | every cycle out_strobe high
//
//  One event per clock while busy is low. The event bytes land in the input
//  register, the conversion settles between that and the result register,
//  and the result shows for one cycle with out_strobe.
//  Reset (rst_n low, synchronous) clears both valid flags and holds busy
//  high; busy drops in the cycle after reset is released and stays low.
//  The receiver cannot stall; the pipe never holds an event back.
//
module tracker_pattern_event_converter_core
  import tpec_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [7:0]         in_event_byte0,
  input  logic [7:0]         in_event_byte1,
  input  logic [7:0]         in_event_byte2,
  input  logic [7:0]         in_event_byte3,
  output logic               out_strobe,
  output logic [EVENT_W-1:0] out_packed_event
);

  // --------------------------------------------------------------------------
  // Input register
  // --------------------------------------------------------------------------
  logic       busy_r;
  logic       in_vld_r;
  logic [7:0] b0_r, b1_r, b2_r, b3_r;
  logic       accept;

  assign busy   = busy_r;
  assign accept = start && !busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b1;
      in_vld_r <= 1'b0;
    end else begin
      busy_r   <= 1'b0;
      in_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b0_r <= in_event_byte0;
      b1_r <= in_event_byte1;
      b2_r <= in_event_byte2;
      b3_r <= in_event_byte3;
    end
  end

  // --------------------------------------------------------------------------
  // Field split
  // --------------------------------------------------------------------------
  period_t          period;
  logic [7:0]       ins_raw;
  logic [INS_W-1:0] ins;
  fx_t              fx;
  param_t           par;
  fx_t              par_hi;
  fx_t              par_lo;

  assign period  = {b0_r[3:0], b1_r};
  assign ins_raw = {b0_r[7:4], b2_r[7:4]} - 8'd1;   // instrument zero wraps
  assign ins     = ins_raw[INS_W-1:0];
  assign fx      = b2_r[3:0];
  assign par     = b3_r;
  assign par_hi  = par[7:4];
  assign par_lo  = par[3:0];

  // --------------------------------------------------------------------------
  // Period to note
  // Normalize the period so bit 11 is set; each left shift is one octave
  // (12 semitones). Within the octave the semitone is the count of
  // thresholds the normalized period does not exceed.
  // --------------------------------------------------------------------------
  logic [3:0]        lz;
  period_t           pnorm;
  logic [3:0]        thr_cnt;
  logic [7:0]        note_sum;
  logic [NOTE_W-1:0] note;

  always_comb begin
    lz = 4'd0;
    for (int i = 0; i < PERIOD_W; i++) begin
      if (period[i]) lz = 4'(PERIOD_W - 1 - i);
    end
  end

  assign pnorm = period << lz;

  always_comb begin
    thr_cnt = 4'd0;
    for (int i = 0; i < NUM_THR; i++) begin
      thr_cnt = thr_cnt + {3'b0, (pnorm <= NOTE_THR[i])};
    end
  end

  assign note_sum = ({4'b0, lz} << 3) + ({4'b0, lz} << 2) + {4'b0, thr_cnt} - NOTE_BIAS;
  assign note     = (period == '0) ? NOTE_EMPTY : note_sum[NOTE_W-1:0];

  // --------------------------------------------------------------------------
  // Panning scale: floor(x*64/255) = (64x + x/4 + 1) >> 8 for byte x
  // --------------------------------------------------------------------------
  logic [14:0] pan_sum;
  logic [6:0]  pan_v;

  assign pan_sum = {1'b0, par, 6'b0} + {9'b0, par[7:2]} + 15'd1;
  assign pan_v   = pan_sum[14:8];

  // --------------------------------------------------------------------------
  // Effect remap
  // --------------------------------------------------------------------------
  fx_t              fx_out;
  param_t           par_out;
  logic [VOL_W-1:0] vol;

  always_comb begin
    fx_out  = fx;
    par_out = par;
    vol     = VOL_EMPTY;
    unique case (fx)
      SRC_ARP: begin
        if (par != '0) begin
          fx_out = DST_ARP;
        end else begin
          fx_out  = FX_EMPTY;
          par_out = PARAM_EMPTY;
        end
      end
      SRC_PORTA_UP: fx_out = DST_PORTA_UP;
      SRC_PORTA_DN: fx_out = DST_PORTA_DN;
      SRC_TONE:     fx_out = DST_TONE;
      SRC_VIB:      fx_out = DST_VIB;
      SRC_TONE_VS: begin
        fx_out  = DST_MISC;
        par_out = (par_lo != '0) ? {MSC_TONVS_DN, par_lo} : {MSC_TONVS_UP, par_hi};
      end
      SRC_VIB_VS: begin
        fx_out  = DST_MISC;
        par_out = (par_lo != '0) ? {MSC_VIBVS_DN, par_lo} : {MSC_VIBVS_UP, par_hi};
      end
      SRC_TREM: fx_out = DST_TREM;
      SRC_PAN: begin
        fx_out  = DST_PAN;
        par_out = to_bcd(pan_v);
      end
      SRC_OFFSET: fx_out = DST_OFFSET;
      SRC_VSLIDE: fx_out = DST_VSLIDE;
      SRC_JUMP:   fx_out = DST_JUMP;
      SRC_SET_VOL: begin
        vol     = par[VOL_W-1:0];
        fx_out  = FX_EMPTY;
        par_out = PARAM_EMPTY;
      end
      SRC_BREAK: fx_out = DST_BREAK;
      SRC_EXT: begin
        fx_out = DST_EXT;
        unique case (par_hi) inside
          SX_FILTER: begin
            fx_out  = DST_MISC;
            par_out = {MSC_FILTER, par_lo};
          end
          SX_FINE_UP:   par_out = {EXT_FINE_UP, par_lo};
          SX_FINE_DN:   par_out = {EXT_FINE_DN, par_lo};
          SX_GLISS, SX_FINETUNE: begin
            fx_out  = FX_EMPTY;
            par_out = PARAM_EMPTY;
          end
          SX_VIB_WAVE:  par_out = {EXT_VIB_WAVE, par_lo};
          SX_LOOP:      par_out = {EXT_LOOP, par_lo};
          SX_TREM_WAVE: par_out = {EXT_TREM_WAVE, par_lo};
          SX_PAN: begin
            fx_out  = DST_PAN;
            par_out = to_bcd({1'b0, par_lo, 2'b0});
          end
          SX_RETRIG:    par_out = {EXT_RETRIG, par_lo};
          SX_FVOL_UP:   par_out = {EXT_FVOL_UP, par_lo};
          SX_FVOL_DN:   par_out = {EXT_FVOL_DN, par_lo};
          SX_CUT:       par_out = {EXT_CUT, par_lo};
          SX_DELAY:     par_out = {EXT_DELAY, par_lo};
          SX_PDELAY:    par_out = {EXT_PDELAY, par_lo};
          SX_INV_LOOP: begin
            fx_out  = DST_MISC;
            par_out = {MSC_INV_LOOP, par_lo};
          end
          default: begin
            fx_out  = FX_EMPTY;
            par_out = PARAM_EMPTY;
          end
        endcase
      end
      SRC_SPEED: fx_out = DST_SPEED;
      default:   fx_out = DST_SPEED;
    endcase
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  logic               out_strobe_r;
  logic [EVENT_W-1:0] out_event_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld_r) begin
      out_event_r <= {par_out, fx_out, vol, ins, note};
    end
  end

  assign out_strobe       = out_strobe_r;
  assign out_packed_event = out_event_r;

endmodule

FILE: src/tpec_checker.sv
// ----------------------------------------------------------------------------
// tpec_checker
// Port-level timing and field checks for the pattern event converter.
// ----------------------------------------------------------------------------
module tpec_checker
  import tpec_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic [7:0]         in_event_byte0,
  input logic [7:0]         in_event_byte1,
  input logic [7:0]         in_event_byte2,
  input logic [7:0]         in_event_byte3,
  input logic               out_strobe,
  input logic [EVENT_W-1:0] out_packed_event
);

  // every accepted event yields a result through the input and result registers
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##1 out_strobe)
    else $error("accepted event produced no result");

  // no result without an earlier accepted event
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, 2))
    else $error("result without a matching transfer");

  // empty period gives an empty note field
  a_empty_note: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && $past((in_event_byte0[3:0] == 4'h0) && (in_event_byte1 == 8'h00), 2))
      |-> (out_packed_event[NOTE_W-1:0] == NOTE_EMPTY))
    else $error("zero period did not give empty note");

  // set-volume leaves the effect and parameter empty
  a_set_vol: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && $past(in_event_byte2[3:0] == SRC_SET_VOL, 2))
      |-> (out_packed_event[EVENT_W-1:EVENT_W-FX_W-PARAM_W] == '1))
    else $error("set-volume left an effect");

  // busy only around reset
  a_busy_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !busy)
    else $error("busy outside reset");

endmodule

bind tracker_pattern_event_converter_core tpec_checker u_tpec_checker (.*);
